/* rtl/core/assert_macros.svh */
// assertion macros shared by the reassembler rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

/* rtl/core/frasm_pkg.sv */
// types and constants of the fragment reassembler
package frasm_pkg;

   localparam int MAX_PAYLOAD   = 64;
   localparam int MAX_FRAGMENTS = 32;
   localparam int HEADER_BYTES  = 4;
   localparam int STORE_DEPTH   = 2048;

   localparam int STAGE_AW = $clog2(MAX_PAYLOAD);
   localparam int STORE_AW = $clog2(STORE_DEPTH);
   localparam int CSR_AW   = 1;
   localparam int CSR_DW   = 8;

   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

   localparam logic [1:0] ST_MORE  = 2'd0;
   localparam logic [1:0] ST_READY = 2'd1;
   localparam logic [1:0] ST_BAD   = 2'd2;

   localparam logic ACT_FRAGMENT = 1'b0;
   localparam logic ACT_READ     = 1'b1;

   localparam logic [CSR_AW-1:0] CSR_PAYLOAD_SIZE = 1'd0;
   localparam logic [CSR_AW-1:0] CSR_FRAME_MAGIC  = 1'd1;

   localparam logic [6:0] PAYLOAD_SIZE_RESET = 7'd64;
   localparam logic [7:0] FRAME_MAGIC_RESET  = 8'd0;

   typedef struct packed {
      logic        action;
      logic [7:0]  data_byte;
      logic        byte_last;
      logic [10:0] read_address;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [11:0] packet_length;
      logic [7:0]  read_data;
   } rsp_type;

endpackage

/* rtl/core/fragment_reassembler_top.sv */
// Fragment reassembler with received-fragment bitmap, staging buffer and assembly store.
// Fragment bytes are taken one per cycle. On the marked last byte the block checks the header
// and the length; a failing fragment goes straight to the result register. Otherwise it walks
// the payload once through the staging buffer and the assembly store (one byte per cycle on
// their single read and write ports): a copy for a new fragment or a byte compare for a
// duplicate, which ends at once on a mismatch; then come the completion test and the load
// of the result register. A read request goes through the registered read of the assembly
// store to the result register. No request is taken while this work runs; a result
// waiting in the output register does not hold up fragment bytes that produce no result.
`include "assert_macros.svh"

module fragment_reassembler_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  frasm_pkg::req_type                  req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output frasm_pkg::rsp_type                  rsp_data,
   input  logic                                csr_write,
   input  logic [frasm_pkg::CSR_AW-1:0]        csr_index,
   input  logic [frasm_pkg::CSR_DW-1:0]        csr_wdata
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_CMP   = 3'd2;
   localparam logic [2:0] S_COPY  = 3'd3;
   localparam logic [2:0] S_FINAL = 3'd4;
   localparam logic [2:0] S_READ  = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;

   logic [7:0] stage_mem [frasm_pkg::MAX_PAYLOAD];
   logic [7:0] store_mem [frasm_pkg::STORE_DEPTH];

   logic [2:0]  state_ff, state_in;
   logic        rsp_valid_ff, rsp_valid_in;
   frasm_pkg::rsp_type rsp_data_ff, rsp_data_in;
   frasm_pkg::rsp_type res_ff, res_in;

   logic [6:0]  payload_size_ff, payload_size_in;
   logic [7:0]  frame_magic_ff, frame_magic_in;

   logic        assembling_ff, assembling_in;
   logic [7:0]  assembly_id_ff, assembly_id_in;
   logic [5:0]  assembly_total_ff, assembly_total_in;
   logic [31:0] received_mask_ff, received_mask_in;
   logic [6:0]  final_size_ff, final_size_in;
   logic [11:0] assembled_length_ff, assembled_length_in;
   logic [7:0]  byte_position_ff, byte_position_in;
   logic [7:0]  header_id_ff, header_id_in;
   logic [7:0]  header_index_ff, header_index_in;
   logic [7:0]  header_total_ff, header_total_in;
   logic        fragment_error_ff, fragment_error_in;

   logic [frasm_pkg::STORE_AW-1:0] off_ff, off_in;
   logic [6:0]  psz_ff, psz_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        pend_ff, pend_in;
   logic [frasm_pkg::STORE_AW-1:0] wr_addr_ff, wr_addr_in;

   logic        req_accept;
   logic        out_free;

   logic        stage_we;
   logic [frasm_pkg::STAGE_AW-1:0] stage_wa;
   logic [frasm_pkg::STAGE_AW-1:0] stage_ra;
   logic [7:0]  stage_q;
   logic        store_we;
   logic [frasm_pkg::STORE_AW-1:0] store_ra;
   logic [7:0]  store_q;

   logic [7:0]  stage_offset;
   logic [7:0]  psz8;
   logic        is_final;
   logic        restart;
   logic        dup;
   logic [6:0]  have;
   logic [11:0] off_full;
   logic [12:0] span_end;
   logic        bad;
   logic [31:0] one_hot_idx;
   logic [4:0]  tot_m1;
   logic [31:0] full_mask;
   logic        all_in;
   logic [11:0] length_full;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // receive side staging write
   assign stage_offset = byte_position_ff - 8'(frasm_pkg::HEADER_BYTES);
   assign stage_we = req_accept && (req_data.action == frasm_pkg::ACT_FRAGMENT)
                     && (byte_position_ff >= 8'(frasm_pkg::HEADER_BYTES))
                     && ({2'b00, byte_position_ff}
                         < 10'(frasm_pkg::HEADER_BYTES + frasm_pkg::MAX_PAYLOAD));
   assign stage_wa = stage_offset[frasm_pkg::STAGE_AW-1:0];
   assign stage_ra = cnt_ff[frasm_pkg::STAGE_AW-1:0];

   assign store_ra = (state_ff == S_CMP) ? (off_ff + frasm_pkg::STORE_AW'(cnt_ff))
                                         : req_data.read_address;
   assign store_we = (state_ff == S_COPY) && pend_ff;

   always_ff @(posedge clock) begin
      if (stage_we) begin
         stage_mem[stage_wa] <= req_data.data_byte;
      end
      stage_q <= stage_mem[stage_ra];
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[wr_addr_ff] <= stage_q;
      end
      store_q <= store_mem[store_ra];
   end

   // fragment checks
   assign psz8     = byte_position_ff - 8'(frasm_pkg::HEADER_BYTES);
   assign is_final = (header_index_ff == header_total_ff - 8'd1);
   assign restart  = !assembling_ff || (assembly_id_ff != header_id_ff);
   assign dup      = !restart && received_mask_ff[header_index_ff[4:0]];
   assign have     = is_final ? final_size_ff : payload_size_ff;
   assign off_full = {7'b0, header_index_ff[4:0]} * {5'b0, payload_size_ff};
   assign span_end = {1'b0, off_full} + {5'b0, psz8};
   assign one_hot_idx = 32'd1 << header_index_ff[4:0];

   always_comb begin
      bad = 1'b0;
      if (payload_size_ff == 7'd0
          || {1'b0, payload_size_ff} > 8'(frasm_pkg::MAX_PAYLOAD)
          || byte_position_ff <= 8'(frasm_pkg::HEADER_BYTES)) begin
         bad = 1'b1;
      end
      if (fragment_error_ff) begin
         bad = 1'b1;
      end
      if (header_total_ff == 8'd0
          || header_total_ff > 8'(frasm_pkg::MAX_FRAGMENTS)
          || header_index_ff >= header_total_ff) begin
         bad = 1'b1;
      end
      if (psz8 > {1'b0, payload_size_ff}
          || (!is_final && psz8 != {1'b0, payload_size_ff})) begin
         bad = 1'b1;
      end
      if (!restart && {2'b00, assembly_total_ff} != header_total_ff) begin
         bad = 1'b1;
      end
      if (span_end > 13'(frasm_pkg::STORE_DEPTH)) begin
         bad = 1'b1;
      end
      if (dup && {1'b0, have} != psz8) begin
         bad = 1'b1;
      end
   end

   // completion test
   assign tot_m1      = 5'(assembly_total_ff - 6'd1);
   assign full_mask   = (assembly_total_ff >= 6'(frasm_pkg::MAX_FRAGMENTS))
                        ? frasm_pkg::ALL_ONES
                        : ((32'd1 << assembly_total_ff[4:0]) - 32'd1);
   assign all_in      = ((received_mask_ff & full_mask) == full_mask);
   assign length_full = {7'b0, tot_m1} * {5'b0, payload_size_ff} + {5'b0, final_size_ff};

   always_comb begin
      state_in            = state_ff;
      rsp_valid_in        = rsp_valid_ff;
      rsp_data_in         = rsp_data_ff;
      res_in              = res_ff;
      payload_size_in     = payload_size_ff;
      frame_magic_in      = frame_magic_ff;
      assembling_in       = assembling_ff;
      assembly_id_in      = assembly_id_ff;
      assembly_total_in   = assembly_total_ff;
      received_mask_in    = received_mask_ff;
      final_size_in       = final_size_ff;
      assembled_length_in = assembled_length_ff;
      byte_position_in    = byte_position_ff;
      header_id_in        = header_id_ff;
      header_index_in     = header_index_ff;
      header_total_in     = header_total_ff;
      fragment_error_in   = fragment_error_ff;
      off_in              = off_ff;
      psz_in              = psz_ff;
      cnt_in              = cnt_ff;
      pend_in             = pend_ff;
      wr_addr_in          = wr_addr_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_write) begin
         unique case (csr_index)
            frasm_pkg::CSR_PAYLOAD_SIZE: payload_size_in = csr_wdata[6:0];
            frasm_pkg::CSR_FRAME_MAGIC:  frame_magic_in  = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_data.action == frasm_pkg::ACT_READ) begin
                  state_in = S_READ;
               end else begin
                  unique case (byte_position_ff)
                     8'd0: begin
                        if (req_data.data_byte != frame_magic_ff) begin
                           fragment_error_in = 1'b1;
                        end
                     end
                     8'd1: header_id_in    = req_data.data_byte;
                     8'd2: header_index_in = req_data.data_byte;
                     8'd3: header_total_in = req_data.data_byte;
                     default: ;
                  endcase
                  if (byte_position_ff != 8'hFF) begin
                     byte_position_in = byte_position_ff + 8'd1;
                  end
                  if (req_data.byte_last) begin
                     state_in = S_CHECK;
                  end
               end
            end
         end
         S_CHECK: begin
            byte_position_in  = 8'd0;
            fragment_error_in = 1'b0;
            off_in            = off_full[frasm_pkg::STORE_AW-1:0];
            psz_in            = psz8[6:0];
            cnt_in            = 7'd0;
            pend_in           = 1'b0;
            if (bad) begin
               res_in   = '{status: frasm_pkg::ST_BAD, packet_length: 12'd0, read_data: 8'd0};
               state_in = S_OUT;
            end else if (dup) begin
               state_in = S_CMP;
            end else begin
               if (restart) begin
                  assembly_id_in    = header_id_ff;
                  assembly_total_in = header_total_ff[5:0];
                  assembling_in     = 1'b1;
                  received_mask_in  = one_hot_idx;
                  final_size_in     = 7'd0;
               end else begin
                  received_mask_in  = received_mask_ff | one_hot_idx;
               end
               if (is_final) begin
                  final_size_in = psz8[6:0];
               end
               state_in = S_COPY;
            end
         end
         S_CMP: begin
            if (pend_ff && store_q != stage_q) begin
               res_in   = '{status: frasm_pkg::ST_BAD, packet_length: 12'd0, read_data: 8'd0};
               state_in = S_OUT;
            end else if (cnt_ff == psz_ff && !pend_ff) begin
               state_in = S_FINAL;
            end else begin
               pend_in = (cnt_ff != psz_ff);
               if (cnt_ff != psz_ff) begin
                  cnt_in = cnt_ff + 7'd1;
               end
            end
         end
         S_COPY: begin
            if (cnt_ff == psz_ff && !pend_ff) begin
               state_in = S_FINAL;
            end else begin
               pend_in    = (cnt_ff != psz_ff);
               wr_addr_in = off_ff + frasm_pkg::STORE_AW'(cnt_ff);
               if (cnt_ff != psz_ff) begin
                  cnt_in = cnt_ff + 7'd1;
               end
            end
         end
         S_FINAL: begin
            if (all_in) begin
               assembling_in       = 1'b0;
               assembled_length_in = length_full;
               res_in = '{status: frasm_pkg::ST_READY, packet_length: length_full,
                          read_data: 8'd0};
            end else begin
               res_in = '{status: frasm_pkg::ST_MORE, packet_length: 12'd0, read_data: 8'd0};
            end
            state_in = S_OUT;
         end
         S_READ: begin
            res_in   = '{status: frasm_pkg::ST_MORE, packet_length: 12'd0, read_data: store_q};
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= S_IDLE;
         rsp_valid_ff        <= 1'b0;
         payload_size_ff     <= frasm_pkg::PAYLOAD_SIZE_RESET;
         frame_magic_ff      <= frasm_pkg::FRAME_MAGIC_RESET;
         assembling_ff       <= 1'b0;
         assembly_id_ff      <= 8'd0;
         assembly_total_ff   <= 6'd0;
         received_mask_ff    <= 32'd0;
         final_size_ff       <= 7'd0;
         assembled_length_ff <= 12'd0;
         byte_position_ff    <= 8'd0;
         header_id_ff        <= 8'd0;
         header_index_ff     <= 8'd0;
         header_total_ff     <= 8'd0;
         fragment_error_ff   <= 1'b0;
         cnt_ff              <= 7'd0;
         pend_ff             <= 1'b0;
      end else begin
         state_ff            <= state_in;
         rsp_valid_ff        <= rsp_valid_in;
         payload_size_ff     <= payload_size_in;
         frame_magic_ff      <= frame_magic_in;
         assembling_ff       <= assembling_in;
         assembly_id_ff      <= assembly_id_in;
         assembly_total_ff   <= assembly_total_in;
         received_mask_ff    <= received_mask_in;
         final_size_ff       <= final_size_in;
         assembled_length_ff <= assembled_length_in;
         byte_position_ff    <= byte_position_in;
         header_id_ff        <= header_id_in;
         header_index_ff     <= header_index_in;
         header_total_ff     <= header_total_in;
         fragment_error_ff   <= fragment_error_in;
         cnt_ff              <= cnt_in;
         pend_ff             <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      res_ff      <= res_in;
      off_ff      <= off_in;
      psz_ff      <= psz_in;
      wr_addr_ff  <= wr_addr_in;
   end

   // a response is only raised from the output load state
   `ASSERT_CLK(a_rsp_from_out, clock, reset, $rose(rsp_valid_ff) |-> ($past(state_ff) == S_OUT))
   // compare walk only runs for a duplicate of a received fragment
   `ASSERT_CLK(a_cmp_is_dup, clock, reset, (state_ff == S_CMP) |-> (assembling_ff && received_mask_ff[header_index_ff[4:0]]))
   // byte walk never passes the fragment length
   `ASSERT_NEVER(a_walk_bound, clock, reset, (state_ff == S_CMP || state_ff == S_COPY) && (cnt_ff > psz_ff || psz_ff == 7'd0))
   // a complete packet ends the assembly
   `ASSERT_CLK(a_ready_ends, clock, reset, (state_ff == S_FINAL && all_in) |=> !assembling_ff)

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// self-checking testbench of the fragment reassembler: request driver, response monitor, checker
module tb_top;
   import frasm_pkg::*;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int LONG_HOLD     = 400;
   localparam int SETTLE_CYCLES = 80;
   localparam int QUEUE_ROOM    = 4;
   localparam int RANDOM_ITEMS  = 550;
   localparam int MIN_RESULTS   = 60;

   typedef enum int {FRAG_FRESH, FRAG_REPEAT, FRAG_ALTER} frag_kind_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_write = 1'b0;
   logic [CSR_AW-1:0] csr_index = '0;
   logic [CSR_DW-1:0] csr_wdata = '0;

   // reassembly state as the block should hold it
   logic [7:0] store_mem [0:STORE_DEPTH-1];
   logic [7:0] stage_mem [0:MAX_PAYLOAD-1];
   bit written_flag [0:STORE_DEPTH-1];
   int written_addr[$];
   bit assembling;
   logic [7:0] asm_id = '0;
   logic [5:0] asm_total = '0;
   logic [31:0] got_mask = '0;
   logic [6:0] final_len = '0;
   logic [11:0] pkt_len = '0;
   logic [7:0] frag_pos = '0;
   logic [7:0] hdr_id = '0;
   logic [7:0] hdr_index = '0;
   logic [7:0] hdr_total = '0;
   bit magic_bad;
   logic [6:0] cfg_payload = PAYLOAD_SIZE_RESET;
   logic [7:0] cfg_magic = FRAME_MAGIC_RESET;

   req_type queued_req[$];
   rsp_type awaited_rsp[$];
   bit offering;
   bit send_idle;
   bit recv_idle;
   int send_gap;
   int stall_left;
   int hold_left;
   int hold_asks;
   int hold_seen;
   int read_pct;
   int items_sent;
   int results_seen;
   int fail_count;
   int cycle_count;
   int phase_payload = PAYLOAD_SIZE_RESET;
   logic [7:0] phase_magic = FRAME_MAGIC_RESET;
   bit [7:0] sent_payload [0:31][0:MAX_PAYLOAD-1];

   fragment_reassembler_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic void take_fragment_byte(logic [7:0] b);
      if (frag_pos == 8'd0) begin
         if (b != cfg_magic) magic_bad = 1'b1;
      end else if (frag_pos == 8'd1) begin
         hdr_id = b;
      end else if (frag_pos == 8'd2) begin
         hdr_index = b;
      end else if (frag_pos == 8'd3) begin
         hdr_total = b;
      end else if (frag_pos - HEADER_BYTES < MAX_PAYLOAD) begin
         stage_mem[frag_pos - HEADER_BYTES] = b;
      end
      if (frag_pos != 8'd255) frag_pos++;
   endfunction

   function automatic logic [1:0] judge_fragment();
      int unsigned count, pay, idx, tot, psz, off, have, i;
      bit restart, dup, differs;
      logic [31:0] full;
      count = frag_pos;
      pay = cfg_payload;
      idx = hdr_index;
      tot = hdr_total;
      if (pay == 0 || pay > MAX_PAYLOAD || count <= HEADER_BYTES) return ST_BAD;
      if (magic_bad) return ST_BAD;
      if (tot == 0 || tot > MAX_FRAGMENTS || idx >= tot) return ST_BAD;
      psz = count - HEADER_BYTES;
      if (psz > pay) return ST_BAD;
      if (idx != tot - 1 && psz != pay) return ST_BAD;
      restart = !assembling || asm_id != hdr_id;
      if (!restart && asm_total != tot) return ST_BAD;
      off = idx * pay;
      if (off + psz > STORE_DEPTH) return ST_BAD;
      dup = !restart && got_mask[idx];
      if (dup) begin
         have = (idx == tot - 1) ? final_len : pay;
         differs = (have != psz);
         for (i = 0; i < psz && !differs; i++) begin
            if (store_mem[off + i] != stage_mem[i]) differs = 1'b1;
         end
         if (differs) return ST_BAD;
      end
      if (restart) begin
         asm_id = hdr_id;
         asm_total = tot;
         got_mask = '0;
         final_len = '0;
         assembling = 1'b1;
      end
      if (!dup) begin
         for (i = 0; i < psz; i++) begin
            store_mem[off + i] = stage_mem[i];
            if (!written_flag[off + i]) begin
               written_flag[off + i] = 1'b1;
               written_addr.push_back(off + i);
            end
         end
         got_mask[idx] = 1'b1;
         if (idx == tot - 1) final_len = psz;
      end
      full = (tot >= 32) ? ALL_ONES : ((32'd1 << tot) - 32'd1);
      if ((got_mask & full) == full) begin
         assembling = 1'b0;
         pkt_len = 12'((tot - 1) * pay + final_len);
         return ST_READY;
      end
      return ST_MORE;
   endfunction

   function automatic void reassemble(req_type r);
      rsp_type res;
      res = '0;
      if (r.action == ACT_READ) begin
         res.status = ST_MORE;
         res.read_data = store_mem[r.read_address];
         awaited_rsp.push_back(res);
      end else begin
         take_fragment_byte(r.data_byte);
         if (r.byte_last) begin
            res.status = judge_fragment();
            if (res.status == ST_READY) res.packet_length = pkt_len;
            frag_pos = '0;
            magic_bad = 1'b0;
            awaited_rsp.push_back(res);
         end
      end
   endfunction

   function automatic void check_rsp(rsp_type got);
      rsp_type want;
      results_seen++;
      if (awaited_rsp.size() == 0) begin
         $display("%0t: unexpected response status %0d length %0d data %02h",
                  $time, got.status, got.packet_length, got.read_data);
         fail_count++;
         return;
      end
      want = awaited_rsp.pop_front();
      if (got.status !== want.status) begin
         $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
         fail_count++;
      end
      if (got.packet_length !== want.packet_length) begin
         $display("%0t: packet length expected %0d got %0d",
                  $time, want.packet_length, got.packet_length);
         fail_count++;
      end
      if (got.read_data !== want.read_data) begin
         $display("%0t: read data expected %02h got %02h", $time, want.read_data, got.read_data);
         fail_count++;
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            reassemble(req_data);
            offering = 1'b0;
            send_gap = send_idle ? $urandom_range(16, 0) : 0;
         end
         if (!offering) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (queued_req.size() != 0) begin
               req_data <= queued_req.pop_front();
               offering = 1'b1;
            end
         end
         req_valid <= offering;
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            check_rsp(rsp_data);
            stall_left = recv_idle ? $urandom_range(16, 0) : 0;
         end
         if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic push_req(req_type r);
      while (queued_req.size() >= QUEUE_ROOM) @(posedge clock);
      queued_req.push_back(r);
      items_sent++;
   endtask

   task automatic push_read(int addr);
      req_type r;
      r = '0;
      r.action = ACT_READ;
      r.data_byte = $urandom;
      r.byte_last = $urandom;
      r.read_address = addr;
      push_req(r);
   endtask

   task automatic push_byte(logic [7:0] b, bit fin);
      req_type r;
      r = '0;
      r.action = ACT_FRAGMENT;
      r.data_byte = b;
      r.byte_last = fin;
      r.read_address = $urandom;
      // reads only ever target bytes already written
      if (written_addr.size() != 0 && $urandom_range(99, 0) < read_pct)
         push_read(written_addr[$urandom_range(written_addr.size() - 1, 0)]);
      push_req(r);
   endtask

   task automatic push_runt(int n);
      int i;
      for (i = 0; i < n; i++) push_byte($urandom, i == n - 1);
   endtask

   task automatic push_fragment(logic [7:0] magic, id, idx, tot, int len, frag_kind_type kind);
      int i, slot, flip;
      logic [7:0] b;
      slot = idx % 32;
      flip = (len > 0) ? $urandom_range(len - 1, 0) : 0;
      push_byte(magic, 1'b0);
      push_byte(id, 1'b0);
      push_byte(idx, 1'b0);
      push_byte(tot, len == 0);
      for (i = 0; i < len; i++) begin
         if (kind == FRAG_FRESH || i >= MAX_PAYLOAD) begin
            b = $urandom;
         end else begin
            b = sent_payload[slot][i];
         end
         if (kind == FRAG_ALTER && i == flip) b = ~b;
         if (kind == FRAG_FRESH && i < MAX_PAYLOAD) sent_payload[slot][i] = b;
         push_byte(b, i == len - 1);
      end
   endtask

   task automatic push_packet();
      int tot, fin_len, pay, k, n, pick;
      int order[$];
      logic [7:0] id;
      frag_kind_type kind;
      pay = (phase_payload >= 1 && phase_payload <= MAX_PAYLOAD) ? phase_payload
                                                                 : $urandom_range(8, 1);
      if ($urandom_range(7, 0) == 0 && pay <= 8) begin
         tot = $urandom_range(MAX_FRAGMENTS, 1);
      end else begin
         tot = $urandom_range(4, 1);
      end
      fin_len = $urandom_range(pay, 1);
      id = $urandom_range(7, 0);
      for (k = 0; k < tot; k++) order.push_back(k);
      order.shuffle();
      if (tot > 1 && $urandom_range(9, 0) == 0) void'(order.pop_back());
      n = order.size();
      for (k = 0; k < n; k++) begin
         push_fragment(phase_magic, id, order[k], tot, (order[k] == tot - 1) ? fin_len : pay,
                       FRAG_FRESH);
         if ($urandom_range(6, 0) == 0) begin
            pick = order[$urandom_range(k, 0)];
            kind = ($urandom_range(2, 0) == 0) ? FRAG_ALTER : FRAG_REPEAT;
            push_fragment(phase_magic, id, pick, tot, (pick == tot - 1) ? fin_len : pay, kind);
         end
      end
   endtask

   task automatic push_noise();
      int pay, tot;
      logic [7:0] id;
      pay = (phase_payload >= 1 && phase_payload <= MAX_PAYLOAD) ? phase_payload : 8;
      id = $urandom_range(7, 0);
      case ($urandom_range(7, 0))
         0: push_runt($urandom_range(HEADER_BYTES, 1));
         1: push_fragment(phase_magic ^ 8'($urandom_range(255, 1)), id, 0, 1, 1, FRAG_FRESH);
         2: begin
            tot = ($urandom_range(1, 0) == 0) ? 0 : $urandom_range(255, MAX_FRAGMENTS + 1);
            push_fragment(phase_magic, id, 0, tot, 1, FRAG_FRESH);
         end
         3: begin
            tot = $urandom_range(MAX_FRAGMENTS, 1);
            push_fragment(phase_magic, id, $urandom_range(255, tot), tot, 1, FRAG_FRESH);
         end
         4: push_fragment(phase_magic, id, 0, 1, pay + $urandom_range(3, 1), FRAG_FRESH);
         5: push_fragment(phase_magic, id, 0, $urandom_range(4, 2),
                          (pay > 1) ? $urandom_range(pay - 1, 1) : 0, FRAG_FRESH);
         6: push_fragment(phase_magic, id, 0, 1, $urandom_range(80, MAX_PAYLOAD + 1),
                          FRAG_FRESH);
         default: push_runt($urandom_range(12, 1));
      endcase
   endtask

   task automatic write_csr(logic [CSR_AW-1:0] idx, logic [CSR_DW-1:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_PAYLOAD_SIZE) begin
         cfg_payload = value[6:0];
      end else begin
         cfg_magic = value;
      end
   endtask

   task automatic settle();
      while (queued_req.size() != 0 || offering || awaited_rsp.size() != 0) @(posedge clock);
      // fragment bytes with no response may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_phase(int payload, logic [7:0] magic);
      settle();
      write_csr(CSR_PAYLOAD_SIZE, payload);
      write_csr(CSR_FRAME_MAGIC, magic);
      phase_payload = payload;
      phase_magic = magic;
      send_idle = $urandom;
      recv_idle = $urandom;
      read_pct = $urandom_range(30, 0);
   endtask

   task automatic pick_phase();
      int payload;
      logic [7:0] magic;
      case ($urandom_range(9, 0))
         0: payload = MAX_PAYLOAD;
         1: payload = ($urandom_range(1, 0) == 0) ? 0 : $urandom_range(127, MAX_PAYLOAD + 1);
         default: payload = $urandom_range(8, 1);
      endcase
      case ($urandom_range(3, 0))
         0: magic = 8'h00;
         1: magic = 8'hFF;
         default: magic = $urandom;
      endcase
      set_phase(payload, magic);
   endtask

   task automatic run_phase(int budget);
      int start;
      start = items_sent;
      while (items_sent - start < budget) begin
         if ($urandom_range(4, 0) == 0) begin
            push_noise();
         end else begin
            push_packet();
         end
      end
   endtask

   initial begin
      int k, rand_start;
      bit hold_done;
      send_idle = 1'b1;
      recv_idle = 1'b1;
      read_pct = 20;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset settings: full payload, zero magic
      push_fragment(8'h00, 8'h00, 0, 1, 2, FRAG_FRESH);
      push_read(0);
      push_read(1);

      set_phase(4, 8'hA5);
      push_fragment(8'hA5, 1, 0, 3, 4, FRAG_FRESH);
      push_fragment(8'hA5, 1, 2, 3, 2, FRAG_FRESH);
      push_fragment(8'hA5, 1, 1, 3, 4, FRAG_FRESH);
      push_read(9);
      push_fragment(8'hA5, 1, 0, 3, 0, FRAG_FRESH);
      push_runt(1);
      push_fragment(8'h5A, 2, 0, 1, 1, FRAG_FRESH);
      push_fragment(8'hA5, 2, 0, 0, 1, FRAG_FRESH);
      push_fragment(8'hA5, 2, 0, 33, 4, FRAG_FRESH);
      push_fragment(8'hA5, 2, 0, 255, 4, FRAG_FRESH);
      push_fragment(8'hA5, 2, 3, 3, 1, FRAG_FRESH);
      push_fragment(8'hA5, 2, 0, 1, 5, FRAG_FRESH);
      push_fragment(8'hA5, 2, 0, 2, 3, FRAG_FRESH);
      push_fragment(8'hA5, 2, 0, 4, 4, FRAG_FRESH);
      push_fragment(8'hA5, 2, 1, 5, 4, FRAG_FRESH);
      push_fragment(8'hA5, 2, 0, 4, 4, FRAG_REPEAT);
      push_fragment(8'hA5, 2, 0, 4, 4, FRAG_ALTER);
      push_fragment(8'hA5, 2, 3, 4, 1, FRAG_FRESH);
      push_fragment(8'hA5, 2, 3, 4, 2, FRAG_REPEAT);
      push_fragment(8'hA5, 2, 3, 4, 1, FRAG_REPEAT);
      push_fragment(8'hA5, 2, 1, 4, 300, FRAG_FRESH);
      push_fragment(8'hA5, 2, 1, 4, 4, FRAG_FRESH);
      push_fragment(8'hA5, 2, 2, 4, 4, FRAG_FRESH);

      set_phase(MAX_PAYLOAD, 8'hFF);
      push_fragment(8'hFF, 7, 31, 32, MAX_PAYLOAD, FRAG_FRESH);
      push_fragment(8'hFF, 7, 0, 32, MAX_PAYLOAD, FRAG_FRESH);
      push_read(STORE_DEPTH - 1);
      push_read(STORE_DEPTH - MAX_PAYLOAD);
      push_read(0);
      push_read(MAX_PAYLOAD - 1);

      set_phase(1, 8'h00);
      for (k = 0; k < MAX_FRAGMENTS; k++) push_fragment(8'h00, 9, k, MAX_FRAGMENTS, 1, FRAG_FRESH);

      set_phase(0, 8'h00);
      push_fragment(8'h00, 1, 0, 1, 1, FRAG_FRESH);
      set_phase(127, 8'h00);
      push_fragment(8'h00, 1, 0, 1, 1, FRAG_FRESH);
      set_phase(MAX_PAYLOAD + 1, 8'h00);
      push_fragment(8'h00, 1, 0, 1, MAX_PAYLOAD, FRAG_FRESH);

      rand_start = items_sent;
      hold_done = 1'b0;
      while (items_sent - rand_start < RANDOM_ITEMS || results_seen < MIN_RESULTS) begin
         pick_phase();
         if (!hold_done) begin
            // long output back-pressure while requests keep coming
            read_pct = 30;
            hold_asks++;
            hold_done = 1'b1;
         end
         run_phase($urandom_range(120, 60));
      end

      settle();
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/frasm_pkg.sv
rtl/core/fragment_reassembler_top.sv
tb/sv/tb_top.sv
